>>> rtl/core/aipa_pkg.sv
`default_nettype none

package aipa_pkg;

    localparam int unsigned POOL_DEPTH_DEF = 4096;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned COUNT_CFG_W    = 13;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam logic [COUNT_CFG_W-1:0] POOL_COUNT_RST = COUNT_CFG_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_START_IP   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = CFG_IDX_W'(1);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [7:0] OCTET_ZERO = 8'h00;
    localparam logic [7:0] OCTET_BCAST = 8'hff;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_BUILD,
        S_IDLE,
        S_POP,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/aipa_link_ram.sv
`default_nettype none

module aipa_link_ram
    import aipa_pkg::*;
#(
    parameter int unsigned DEPTH = POOL_DEPTH_DEF,
    parameter int unsigned WIDTH = 13,
    parameter int unsigned AW    = $clog2(POOL_DEPTH_DEF)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aipa_ctrl.sv
`default_nettype none

module aipa_ctrl
    import aipa_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int unsigned IDX_W      = $clog2(POOL_DEPTH_DEF),
    parameter int unsigned CNT_W      = $clog2(POOL_DEPTH_DEF + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rebuild,
    input  wire logic [ADDR_W-1:0] start_ip,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic              kind,
    input  wire logic [ADDR_W-1:0] address,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic      [ADDR_W-1:0] granted_address,
    output logic      [1:0]        status
);

    localparam int unsigned LINK_W = IDX_W + 1;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               head_valid_reg, head_valid_next;
    logic [CNT_W-1:0]   tries_reg, tries_next;
    logic [IDX_W-1:0]   sweep_reg, sweep_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0]  rsp_addr_reg, rsp_addr_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic [ADDR_W-1:0]  hold_addr_reg, hold_addr_next;
    status_t            hold_status_reg, hold_status_next;

    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    logic [LINK_W-1:0]  mem_wdata, mem_rdata;
    logic               rd_valid;
    logic [IDX_W-1:0]   rd_idx;

    logic               accept, slot_free, fin;
    logic [ADDR_W-1:0]  res_addr;
    status_t            res_status;
    logic [IDX_W-1:0]   last_idx;
    logic [ADDR_W-1:0]  free_off, cand_addr;
    logic               free_in_range, usable;
    logic [CNT_W-1:0]   tries_inc;

    aipa_link_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (LINK_W),
        .AW    (IDX_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_valid  = mem_rdata[LINK_W-1];
    assign rd_idx    = mem_rdata[IDX_W-1:0];
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign last_idx  = IDX_W'(count - CNT_W'(1));
    assign tries_inc = tries_reg + CNT_W'(1);

    assign free_off      = address - start_ip;
    assign free_in_range = free_off < {{(ADDR_W-CNT_W){1'b0}}, count};
    assign cand_addr     = start_ip + {{(ADDR_W-IDX_W){1'b0}}, head_reg};
    assign usable        = (cand_addr[7:0] != OCTET_ZERO) && (cand_addr[7:0] != OCTET_BCAST);

    // datapath and memory control
    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        tries_next      = tries_reg;
        sweep_next      = sweep_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_reg;
        mem_wdata       = {(sweep_reg != '0), IDX_W'(sweep_reg - IDX_W'(1))};
        mem_re          = 1'b0;
        mem_raddr       = head_reg;
        fin             = 1'b0;
        res_addr        = '0;
        res_status      = ST_OK;
        case (state_reg)
            S_BUILD:
            begin
                mem_we = 1'b1;
                if (sweep_reg == last_idx)
                begin
                    head_next       = last_idx;
                    head_valid_next = 1'b1;
                    sweep_next      = '0;
                end
                else
                begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_FREE)
                    begin
                        fin = 1'b1;
                        if (address != '0)
                        begin
                            if (!free_in_range)
                            begin
                                res_status = ST_RANGE;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = free_off[IDX_W-1:0];
                                mem_wdata       = {head_valid_reg, head_reg};
                                head_next       = free_off[IDX_W-1:0];
                                head_valid_next = 1'b1;
                            end
                        end
                    end
                    else if (head_valid_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg;
                        tries_next = '0;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        res_status = ST_EXHAUSTED;
                    end
                end
            end
            S_POP:
            begin
                head_next       = rd_idx;
                head_valid_next = rd_valid;
                tries_next      = tries_inc;
                if (usable)
                begin
                    fin      = 1'b1;
                    res_addr = cand_addr;
                end
                else if (rd_valid && (tries_inc < count))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_idx;
                end
                else
                begin
                    fin        = 1'b1;
                    res_status = ST_EXHAUSTED;
                end
            end
            S_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_BUILD:
            begin
                if (sweep_reg == last_idx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE, S_POP:
            begin
                if (fin)
                begin
                    state_next = slot_free ? S_IDLE : S_HOLD;
                end
                else if (state_reg == S_POP || accept)
                begin
                    state_next = S_POP;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (rebuild)
        begin
            state_next = S_BUILD;
        end
    end

    // result register and hold stage
    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_addr_next    = rsp_addr_reg;
        rsp_status_next  = rsp_status_reg;
        hold_addr_next   = hold_addr_reg;
        hold_status_next = hold_status_reg;
        if (fin && slot_free)
        begin
            rsp_valid_next  = 1'b1;
            rsp_addr_next   = res_addr;
            rsp_status_next = res_status;
        end
        else if (fin)
        begin
            hold_addr_next   = res_addr;
            hold_status_next = res_status;
        end
        else if (state_reg == S_HOLD && slot_free)
        begin
            rsp_valid_next  = 1'b1;
            rsp_addr_next   = hold_addr_reg;
            rsp_status_next = hold_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_BUILD;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            tries_reg      <= '0;
            sweep_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            tries_reg      <= tries_next;
            sweep_reg      <= rebuild ? '0 : sweep_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_addr_reg    <= rsp_addr_next;
        rsp_status_reg  <= rsp_status_next;
        hold_addr_reg   <= hold_addr_next;
        hold_status_reg <= hold_status_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign granted_address = rsp_addr_reg;
    assign status          = rsp_status_reg;

endmodule

`default_nettype wire

>>> rtl/core/ipv4_address_pool_allocator_top.sv
// channel   handshake            payload
// req       req_valid/req_ready  kind, address
// rsp       rsp_valid/rsp_ready  granted_address, status
// cfg       cfg_we               cfg_index, cfg_data
//
// free: the result is formed in the accept cycle; alloc: one link memory read
// per popped entry, stopping at the first usable entry or when exhausted
// after reset and each write to start_ip or pool_count the link memory is
// rebuilt for pool_count entries (clamped to 1..POOL_DEPTH) with req_ready low
// a finished result waits in a hold stage while rsp is stalled; the next
// item is taken once the result has moved to the output register

`default_nettype none

module ipv4_address_pool_allocator_top
    import aipa_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic                  kind,
    input  wire logic [ADDR_W-1:0]     address,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output logic      [ADDR_W-1:0]     granted_address,
    output logic      [1:0]            status
);

    localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
    localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

    logic [ADDR_W-1:0]      start_ip_reg;
    logic [COUNT_CFG_W-1:0] pool_count_reg;
    logic [CFG_DATA_W-1:0]  pool_ext;
    logic [CNT_W-1:0]       count;
    logic                   rebuild;

    assign rebuild = cfg_we && ((cfg_index == CFG_START_IP) || (cfg_index == CFG_POOL_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ip_reg   <= '0;
            pool_count_reg <= POOL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_IP:
                begin
                    start_ip_reg <= cfg_data[ADDR_W-1:0];
                end
                CFG_POOL_COUNT:
                begin
                    pool_count_reg <= cfg_data[COUNT_CFG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // clamp to 1..POOL_DEPTH
    assign pool_ext = {{(CFG_DATA_W-COUNT_CFG_W){1'b0}}, pool_count_reg};

    always_comb
    begin
        if (pool_ext == '0)
        begin
            count = CNT_W'(1);
        end
        else if (pool_ext > CFG_DATA_W'(POOL_DEPTH))
        begin
            count = CNT_W'(POOL_DEPTH);
        end
        else
        begin
            count = pool_ext[CNT_W-1:0];
        end
    end

    aipa_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .rebuild         (rebuild),
        .start_ip        (start_ip_reg),
        .count           (count),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .kind            (kind),
        .address         (address),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .granted_address (granted_address),
        .status          (status)
    );

endmodule

`default_nettype wire

>>> bench/tb_ipv4_address_pool_allocator_top.sv
`timescale 1ns / 100ps

module tb_ipv4_address_pool_allocator_top;
    import aipa_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int DEPTH       = int'(POOL_DEPTH_DEF);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           st;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic                  kind = KIND_ALLOC;
    logic [ADDR_W-1:0]     address = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [ADDR_W-1:0]     granted_address;
    logic [1:0]            status;

    // mirror of the pool
    logic [ADDR_W-1:0]      pool_start;
    logic [COUNT_CFG_W-1:0] pool_count_reg;
    logic [COUNT_CFG_W-1:0] head_off;
    bit                     head_ok;
    logic [COUNT_CFG_W-1:0] link_tbl [DEPTH];
    bit                     link_ok  [DEPTH];

    grant_t            expected_grants[$];
    logic [ADDR_W-1:0] last_grant;
    logic [ADDR_W-1:0] granted_pool[$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    ipv4_address_pool_allocator_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .kind            (kind),
        .address         (address),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .granted_address (granted_address),
        .status          (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 14) - 1;
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= 40)
        begin
            $display("mismatch %s: expected %h got %h at cycle %0d",
                     what, want, got, cycle_count);
        end
    endtask

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_grants.size() == 0)
            begin
                report_mismatch("unexpected result", '0, granted_address);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (granted_address !== want.addr)
                    report_mismatch("granted_address", want.addr, granted_address);
                if (status !== want.st)
                    report_mismatch("status", 32'(want.st), 32'(status));
            end
        end
    end

    function automatic int active_count();
        int n;
        n = int'(pool_count_reg);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    task automatic rebuild_free_list();
        int n;
        n = active_count();
        for (int i = 0; i < DEPTH; i++)
        begin
            link_tbl[i] = '0;
            link_ok[i]  = 1'b0;
        end
        for (int i = 1; i < n; i++)
        begin
            link_tbl[i] = COUNT_CFG_W'(i - 1);
            link_ok[i]  = 1'b1;
        end
        head_off = COUNT_CFG_W'(n - 1);
        head_ok  = 1'b1;
    endtask

    task automatic predict_pool_op(input logic k, input logic [ADDR_W-1:0] a);
        int                n;
        int                tries;
        logic [11:0]       slot;
        logic [ADDR_W-1:0] cand;
        logic [ADDR_W-1:0] off32;
        logic [ADDR_W-1:0] granted;
        status_t           st;
        n       = active_count();
        granted = '0;
        st      = ST_OK;
        if (k == KIND_ALLOC)
        begin
            st    = ST_EXHAUSTED;
            tries = 0;
            while (head_ok && tries < n && st == ST_EXHAUSTED)
            begin
                slot    = head_off[11:0];
                cand    = pool_start + ADDR_W'(slot);
                tries++;
                head_ok  = link_ok[slot];
                head_off = link_tbl[slot];
                if (cand[7:0] != OCTET_ZERO && cand[7:0] != OCTET_BCAST)
                begin
                    granted = cand;
                    st      = ST_OK;
                end
            end
        end
        else if (a != '0)
        begin
            off32 = a - pool_start;
            if (off32 >= ADDR_W'(n))
            begin
                st = ST_RANGE;
            end
            else
            begin
                link_tbl[off32[11:0]] = head_off;
                link_ok[off32[11:0]]  = head_ok;
                head_off = off32[COUNT_CFG_W-1:0];
                head_ok  = 1'b1;
            end
        end
        last_grant = granted;
        expected_grants.push_back('{granted, st});
    endtask

    task automatic send_item(input logic k, input logic [ADDR_W-1:0] a);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        address   <= a;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_pool_op(k, a);
    endtask

    task automatic alloc_item();
        send_item(KIND_ALLOC, '0);
    endtask

    task automatic free_item(input logic [ADDR_W-1:0] a);
        send_item(KIND_FREE, a);
    endtask

    task automatic finish_phase();
        req_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (active_count() + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_IP)
            pool_start = data;
        else if (idx == CFG_POOL_COUNT)
            pool_count_reg = data[COUNT_CFG_W-1:0];
        rebuild_free_list();
        // link table is rebuilt before new items are taken
        repeat (active_count() + 8) @(posedge clk);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] start_addr,
                            input logic [COUNT_CFG_W-1:0] count);
        finish_phase();
        write_reg(CFG_START_IP, start_addr);
        write_reg(CFG_POOL_COUNT, CFG_DATA_W'(count));
        granted_pool.delete();
    endtask

    task automatic test_default_pool();
        alloc_item();
        alloc_item();
        free_item(32'h0000_0000);
        free_item(32'h0000_1000);
        free_item(32'hffff_ffff);
        free_item(32'h0000_0ffe);
        alloc_item();
    endtask

    task automatic test_wrapping_pool();
        // pool runs through .255 and .0 across the top of the address space
        set_pool(32'hffff_fffd, 13'd5);
        repeat (4) alloc_item();
        free_item(32'h0000_0000);
        free_item(32'hffff_fffe);
        alloc_item();
    endtask

    task automatic test_count_limits();
        set_pool(32'h0000_0010, 13'd0);
        alloc_item();
        alloc_item();
        free_item(32'h0000_0011);
        free_item(32'h0000_0010);
        alloc_item();
        set_pool(32'hc0a8_0000, 13'h1fff);
        free_item(32'hc0a8_0fff);
        free_item(32'hc0a8_1000);
        alloc_item();
    endtask

    task automatic test_double_free();
        set_pool(32'h0a00_0000, 13'd4);
        repeat (4) alloc_item();
        // a .0 entry linked to itself exhausts the bounded search
        free_item(32'h0a00_0000);
        free_item(32'h0a00_0000);
        alloc_item();
        alloc_item();
        free_item(32'h0a00_0002);
        free_item(32'h0a00_0002);
        alloc_item();
        alloc_item();
    endtask

    task automatic run_random_phase(input int items);
        int                     r;
        int                     n;
        int                     pick;
        logic [COUNT_CFG_W-1:0] count;
        logic [ADDR_W-1:0]      start_addr;
        logic [ADDR_W-1:0]      a;
        r = $urandom_range(0, 9);
        if (r <= 5)
            count = COUNT_CFG_W'($urandom_range(1, 40));
        else if (r == 6)
            count = COUNT_CFG_W'($urandom_range(41, 300));
        else if (r == 7)
            count = 13'd4096;
        else if (r == 8)
            count = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'h1fff;
        else
            count = 13'd1;
        r = $urandom_range(0, 3);
        if (r == 0)
            start_addr = $urandom;
        else if (r == 1)
            start_addr = 32'hffff_ff00 | 32'($urandom_range(8'he0, 8'hff));
        else
            start_addr = {24'($urandom_range(0, 32'h00ff_ffff)),
                          8'($urandom_range(8'he0, 8'hff))};
        set_pool(start_addr, count);
        n = active_count();
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                alloc_item();
                if (last_grant != '0)
                    granted_pool.push_back(last_grant);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50 && granted_pool.size() != 0)
                begin
                    pick = $urandom_range(0, granted_pool.size() - 1);
                    a    = granted_pool[pick];
                    // leave some entries in place so they get freed twice
                    if ($urandom_range(0, 4) != 0)
                        granted_pool.delete(pick);
                end
                else if (r < 70)
                    a = pool_start + 32'($urandom_range(0, n - 1));
                else if (r < 85)
                    a = pool_start + 32'(n) + 32'($urandom_range(0, 300));
                else if (r < 90)
                    a = '0;
                else
                    a = $urandom;
                free_item(a);
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 8; p++)
        begin
            idle_on = (p != 3);
            run_random_phase(50);
        end
    endtask

    task automatic test_steady_traffic();
        idle_on = 1'b0;
        run_random_phase(50);
    endtask

    initial
    begin
        pool_start     = '0;
        pool_count_reg = POOL_COUNT_RST;
        rebuild_free_list();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_default_pool();
        test_wrapping_pool();
        test_count_limits();
        test_double_free();
        test_random_traffic();
        test_steady_traffic();
        finish_phase();
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
